[rtl/core/apu_pkg.sv]
// ----------------------------------------------------------------------------
// apu_pkg
// Shared widths, pipeline payload types and channel byte positions for the
// alpha unpremultiply pipeline.
// ----------------------------------------------------------------------------
package apu_pkg;

  localparam int CH_W     = 8;                // one colour or alpha byte
  localparam int NUM_W    = 2 * CH_W;         // c*255 + a/2 fits in 16 bits
  localparam int QUOT_W   = CH_W + 1;         // extra top bit flags overflow
  localparam int STEPS    = 3;                // restoring steps per stage
  localparam int DIV_STGS = QUOT_W / STEPS;   // divider stages
  localparam int LANES    = 3;

  // lane order inside the payload
  localparam int LANE_B = 0;
  localparam int LANE_G = 1;
  localparam int LANE_R = 2;

  // byte positions in the pixel word
  localparam int A_LSB = 24;
  localparam int R_LSB = 16;
  localparam int G_LSB = 8;
  localparam int B_LSB = 0;

  localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic [CH_W-1:0]   alpha;
    logic              row_end;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } pipe_t;

endpackage

[rtl/core/apu_div_stage.sv]
// ----------------------------------------------------------------------------
// apu_div_stage
// One register stage of the restoring divider: three quotient bits for each
// colour lane, MSB first, with local valid/ready flow control.
// ----------------------------------------------------------------------------
module apu_div_stage #(
  parameter int TOP_BIT = apu_pkg::QUOT_W - 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  apu_pkg::pipe_t up_i,
  output logic           up_ready_o,
  output apu_pkg::pipe_t dn_o,
  input  logic           dn_ready_i
);

  localparam int DW = apu_pkg::NUM_W + 1;

  logic           valid_r;
  apu_pkg::item_t item_r;
  apu_pkg::item_t item_nxt;

  always_comb begin
    logic [DW-1:0] dsh;
    logic [DW-1:0] rem_w;
    logic          ge;
    item_nxt = up_i.item;
    for (int l = 0; l < apu_pkg::LANES; l++) begin
      for (int s = 0; s < apu_pkg::STEPS; s++) begin
        dsh   = {{(DW - apu_pkg::CH_W){1'b0}}, up_i.item.alpha} << (TOP_BIT - s);
        rem_w = {1'b0, item_nxt.lane[l].rem};
        ge    = (rem_w >= dsh);
        if (ge) begin
          item_nxt.lane[l].rem = item_nxt.lane[l].rem - dsh[apu_pkg::NUM_W-1:0];
        end
        item_nxt.lane[l].quot = {item_nxt.lane[l].quot[apu_pkg::QUOT_W-2:0], ge};
      end
    end
  end

  assign up_ready_o = !valid_r || dn_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready_o) begin
      valid_r <= up_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready_o && up_i.valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_o.valid = valid_r;
  assign dn_o.item  = item_r;

endmodule

[rtl/core/premultiplied_alpha_unpremultiply_unit.sv]
// ----------------------------------------------------------------------------
// premultiplied_alpha_unpremultiply_unit
// Converts premultiplied ARGB32 pixels to straight-alpha bytes, one per clock.
// ----------------------------------------------------------------------------
// Input channel: in_pixel_word (A:R:G:B, alpha in the top byte) and
// in_row_end, transferred when in_valid is high and in_stall low.
// Output channel: out_red_out, out_green_out, out_blue_out, out_alpha_out and
// out_row_end_out, transferred when out_valid is high and out_stall low.
// Each colour becomes (c*255 + a/2) / a, saturated at 255; zero alpha gives
// all four bytes zero. The row-end mark rides along unchanged.
// The pipeline is an input register that forms the numerator, three
// divider stages of three restoring steps each, and the output register.
// One pixel per clock when out_stall is low; the divider is fully pipelined.
// Each stage holds its item while the next is full, so a stall on the output
// fills the bubbles first and only then raises in_stall. Nothing is lost or
// repeated. Reset (synchronous, rst_n low) empties every stage.
// ----------------------------------------------------------------------------
module premultiplied_alpha_unpremultiply_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pixel_word,
  input  logic        in_row_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [7:0]  out_alpha_out,
  output logic        out_row_end_out
);

  localparam int CW = apu_pkg::CH_W;
  localparam int NW = apu_pkg::NUM_W;

  apu_pkg::pipe_t chain [0:apu_pkg::DIV_STGS];
  logic           rdy   [0:apu_pkg::DIV_STGS];

  // ---------------- input stage: numerator c*255 + a/2 ----------------
  logic           s0_valid_r;
  apu_pkg::item_t s0_item_r;
  apu_pkg::item_t s0_item_nxt;
  logic           s0_ready;

  function automatic logic [NW-1:0] numer(input logic [CW-1:0] c,
                                          input logic [CW-1:0] a);
    return {c, {CW{1'b0}}} - {{CW{1'b0}}, c} + {{(CW + 1){1'b0}}, a[CW-1:1]};
  endfunction

  always_comb begin
    logic [CW-1:0] a;
    a = in_pixel_word[apu_pkg::A_LSB +: CW];
    s0_item_nxt.alpha   = a;
    s0_item_nxt.row_end = in_row_end;
    s0_item_nxt.lane[apu_pkg::LANE_R].rem  = numer(in_pixel_word[apu_pkg::R_LSB +: CW], a);
    s0_item_nxt.lane[apu_pkg::LANE_G].rem  = numer(in_pixel_word[apu_pkg::G_LSB +: CW], a);
    s0_item_nxt.lane[apu_pkg::LANE_B].rem  = numer(in_pixel_word[apu_pkg::B_LSB +: CW], a);
    s0_item_nxt.lane[apu_pkg::LANE_R].quot = '0;
    s0_item_nxt.lane[apu_pkg::LANE_G].quot = '0;
    s0_item_nxt.lane[apu_pkg::LANE_B].quot = '0;
  end

  assign s0_ready = !s0_valid_r || rdy[0];
  assign in_stall = !s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_valid) begin
      s0_item_r <= s0_item_nxt;
    end
  end

  assign chain[0].valid = s0_valid_r;
  assign chain[0].item  = s0_item_r;

  // ---------------- divider stages ----------------
  for (genvar k = 0; k < apu_pkg::DIV_STGS; k++) begin : g_div
    apu_div_stage #(
      .TOP_BIT(apu_pkg::QUOT_W - 1 - k * apu_pkg::STEPS)
    ) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_i      (chain[k]),
      .up_ready_o(rdy[k]),
      .dn_o      (chain[k+1]),
      .dn_ready_i(rdy[k+1])
    );
  end

  // ---------------- output stage: saturate, zero alpha ----------------
  logic          out_valid_r;
  logic [CW-1:0] red_r, green_r, blue_r, alpha_r;
  logic          row_end_r;
  apu_pkg::item_t last;

  assign last = chain[apu_pkg::DIV_STGS].item;
  assign rdy[apu_pkg::DIV_STGS] = !out_valid_r || !out_stall;

  // top quotient bit set means the colour exceeded alpha
  function automatic logic [CW-1:0] fin(input apu_pkg::lane_t ln,
                                        input logic [CW-1:0] a);
    logic [CW-1:0] res;
    if (a == '0) begin
      res = '0;
    end else if (ln.quot[apu_pkg::QUOT_W-1]) begin
      res = apu_pkg::CH_MAX;
    end else begin
      res = ln.quot[CW-1:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[apu_pkg::DIV_STGS]) begin
      out_valid_r <= chain[apu_pkg::DIV_STGS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[apu_pkg::DIV_STGS] && chain[apu_pkg::DIV_STGS].valid) begin
      red_r     <= fin(last.lane[apu_pkg::LANE_R], last.alpha);
      green_r   <= fin(last.lane[apu_pkg::LANE_G], last.alpha);
      blue_r    <= fin(last.lane[apu_pkg::LANE_B], last.alpha);
      alpha_r   <= last.alpha;
      row_end_r <= last.row_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_out     = red_r;
  assign out_green_out   = green_r;
  assign out_blue_out    = blue_r;
  assign out_alpha_out   = alpha_r;
  assign out_row_end_out = row_end_r;

  // ---------------- assertions ----------------
  a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_alpha_out == '0) |->
      (out_red_out == '0) && (out_green_out == '0) && (out_blue_out == '0))
    else $error("zero alpha with non-zero colour");

  a_s0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r && !rdy[0] |=> s0_valid_r && $stable(s0_item_r))
    else $error("input stage lost its item while blocked");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    chain[apu_pkg::DIV_STGS].valid && rdy[apu_pkg::DIV_STGS] |=> out_valid)
    else $error("divider result not transferred to output register");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s0_valid_r && out_valid && out_stall)
    else $error("input stalled while pipeline has room");

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for premultiplied_alpha_unpremultiply_unit. Pixels are
// sent in bursts with random gaps, and the output side stalls in changing
// patterns. Every pixel accepted at the input is converted by a local model.
// Each output transfer is checked field by field, in order, against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 500;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [apu_pkg::CH_W-1:0] red;
    logic [apu_pkg::CH_W-1:0] green;
    logic [apu_pkg::CH_W-1:0] blue;
    logic [apu_pkg::CH_W-1:0] alpha;
    logic                     row_end;
  } straight_pixel_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [31:0] in_pixel_word   = '0;
  logic        in_row_end      = 1'b0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic [7:0]  out_alpha_out;
  logic        out_row_end_out;

  straight_pixel_t straight_pixels_due[$];
  int              fail_count  = 0;
  int              cycle_count = 0;
  stall_mode_t     stall_mode  = STALL_NONE;
  int              stall_span  = 0;
  int              stall_tick  = 0;

  premultiplied_alpha_unpremultiply_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_word   (in_pixel_word),
    .in_row_end      (in_row_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .out_alpha_out   (out_alpha_out),
    .out_row_end_out (out_row_end_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // rounded c*255/a, clipped where the colour exceeds alpha
  function automatic logic [apu_pkg::CH_W-1:0] unpremul_byte(
    input logic [apu_pkg::CH_W-1:0] colour,
    input logic [apu_pkg::CH_W-1:0] alpha);
    int unsigned quotient;
    quotient = (int'(colour) * 255 + int'(alpha >> 1)) / int'(alpha);
    return (quotient > 255) ? 8'hff : quotient[apu_pkg::CH_W-1:0];
  endfunction

  function automatic straight_pixel_t straighten(input logic [31:0] word, input logic row_end);
    straight_pixel_t          px;
    logic [apu_pkg::CH_W-1:0] alpha;
    alpha      = word[apu_pkg::A_LSB +: apu_pkg::CH_W];
    px         = '0;
    px.row_end = row_end;
    if (alpha != 0) begin
      px.red   = unpremul_byte(word[apu_pkg::R_LSB +: apu_pkg::CH_W], alpha);
      px.green = unpremul_byte(word[apu_pkg::G_LSB +: apu_pkg::CH_W], alpha);
      px.blue  = unpremul_byte(word[apu_pkg::B_LSB +: apu_pkg::CH_W], alpha);
      px.alpha = alpha;
    end
    return px;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] due, input logic [7:0] got);
    if (got !== due)
      note_failure($sformatf("%s mismatch: expected %0h, got %0h", name, due, got));
  endtask

  // one pixel transfer; returns in the step of the accepting edge
  task automatic send_pixel(input logic [31:0] word, input logic row_end);
    in_valid      <= 1'b1;
    in_pixel_word <= word;
    in_row_end    <= row_end;
    do @(posedge clk); while (in_stall);
    straight_pixels_due.push_back(straighten(word, row_end));
  endtask

  task automatic idle_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    straight_pixel_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (straight_pixels_due.size() == 0) begin
        note_failure($sformatf("unexpected result r=%0h g=%0h b=%0h a=%0h end=%0b",
                               out_red_out, out_green_out, out_blue_out, out_alpha_out,
                               out_row_end_out));
      end else begin
        due = straight_pixels_due.pop_front();
        check_field("red", due.red, out_red_out);
        check_field("green", due.green, out_green_out);
        check_field("blue", due.blue, out_blue_out);
        check_field("alpha", due.alpha, out_alpha_out);
        check_field("row_end", {7'd0, due.row_end}, {7'd0, out_row_end_out});
      end
    end
  end

  // receiver stalls in spans of changing character
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        stall_span <= $urandom_range(20, 150);
      end else begin
        stall_span <= stall_span - 1;
      end
      stall_tick <= stall_tick + 1;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
        STALL_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
        default:        out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic test_zero_alpha();
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h00ff_ffff, 1'b1);
    send_pixel(32'h00a5_c3e1, 1'b0);
  endtask

  task automatic test_extremes();
    send_pixel(32'hffff_ffff, 1'b0);
    send_pixel(32'hff00_0000, 1'b1);
    send_pixel(32'hff80_8080, 1'b1);
    send_pixel(32'h0100_0000, 1'b0);
    send_pixel(32'h0101_0101, 1'b1);
    send_pixel(32'haa55_aa55, 1'b0);
  endtask

  // half-way points of the rounded division
  task automatic test_rounding();
    send_pixel(32'h0201_0101, 1'b0);
    send_pixel(32'h0301_0201, 1'b1);
    send_pixel(32'hfe7f_7f7f, 1'b0);
    send_pixel(32'h807f_4001, 1'b0);
    send_pixel(32'h0502_0304, 1'b1);
  endtask

  // colour above alpha must clip at full scale
  task automatic test_saturation();
    send_pixel(32'h01ff_0201, 1'b0);
    send_pixel(32'h80ff_81ff, 1'b1);
    send_pixel(32'h55aa_55aa, 1'b0);
    send_pixel(32'hfeff_00fe, 1'b1);
  endtask

  task automatic test_random_stream();
    logic [apu_pkg::CH_W-1:0] alpha;
    logic [31:0]              word;
    int                       burst_left;
    int                       pick;
    bit                       no_gaps;
    burst_left = 0;
    no_gaps    = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        if (!no_gaps) begin
          pick = $urandom_range(0, 6);
          if (pick != 0) idle_input(pick);
        end
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed premultiplied pixel
        alpha = 8'($urandom_range(1, 255));
        word  = {alpha, 8'($urandom_range(0, alpha)), 8'($urandom_range(0, alpha)),
                 8'($urandom_range(0, alpha))};
      end else if (pick < 85) begin
        word = $urandom();
      end else if (pick < 95) begin
        word = {8'd0, 24'($urandom())};
      end else begin
        word = {8'($urandom_range(1, 4)), 24'($urandom())};
      end
      send_pixel(word, 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_alpha();
    test_extremes();
    test_rounding();
    test_saturation();
    test_random_stream();
    while (straight_pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/apu_pkg.sv
rtl/core/apu_div_stage.sv
rtl/core/premultiplied_alpha_unpremultiply_unit.sv
sim/testbench.sv
